// ===== src/dwpa_pkg.sv =====
`timescale 1ns / 1ps
package dwpa_pkg;

   localparam int MAX_PERIODS_DEF = 180;
   localparam int LANES_DEF       = 32;

   localparam int KIND_W      = 3;
   localparam int TF_W        = 17;
   localparam int LANE_W      = 5;
   localparam int VALUE_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int SUM_W       = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int YEAR_W      = 7;
   localparam int MONTH_W     = 4;
   localparam int TENTH_W     = 2;

   localparam int TALLY_W     = 16;
   localparam int SCALE_W     = 11;
   localparam int COUNT_W     = 17;

   localparam int MUL_A_W     = 17;
   localparam int MUL_B_W     = 16;
   localparam int MUL_W       = MUL_A_W + MUL_B_W;

   localparam int Q_W         = 8;
   localparam int R_W         = 10;
   localparam int M_W         = 7;
   localparam int D_W         = 4;
   localparam int CODE_W      = 14;

   localparam int TF_YEAR_DIV       = 1000;
   localparam int DIV1000_RECIP     = 1048;
   localparam int DIV1000_SHIFT     = 20;
   localparam int TF_MONTH_DIV      = 10;
   localparam int DIV10_RECIP       = 205;
   localparam int DIV10_SHIFT       = 11;
   localparam int PERIODS_PER_YEAR  = 36;
   localparam int PERIODS_PER_MONTH = 3;

   localparam int SCALE_INIT  = 1024;
   localparam int COUNT_STEP  = 16;
   localparam int STEP_BITS   = $clog2(COUNT_STEP);
   localparam int COUNT_BIAS  = 2;
   localparam int TALLY_MAX   = 65535;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 3'd0,
      KIND_COUNT = 3'd1,
      KIND_BUILD = 3'd2,
      KIND_ACCUM = 3'd3,
      KIND_READ  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_AGE_NEG = 2'd1,
      STATUS_AGE_OLD = 2'd2,
      STATUS_TF_ZERO = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOW_YEAR  = 2'd0,
      CSR_NOW_MONTH = 2'd1,
      CSR_NOW_TENTH = 2'd2
   } csr_type;

   typedef enum logic [13:0] {
      ST_SWEEP    = 14'b00000000000001,
      ST_IDLE     = 14'b00000000000010,
      ST_DIV1     = 14'b00000000000100,
      ST_DIV2     = 14'b00000000001000,
      ST_DIV3     = 14'b00000000010000,
      ST_DIV4     = 14'b00000000100000,
      ST_AGE      = 14'b00000001000000,
      ST_CNT      = 14'b00000010000000,
      ST_ACC_MUL  = 14'b00000100000000,
      ST_ACC_WR   = 14'b00001000000000,
      ST_RDOUT    = 14'b00010000000000,
      ST_BLD_RD   = 14'b00100000000000,
      ST_BLD_ADD  = 14'b01000000000000,
      ST_BLD_STEP = 14'b10000000000000
   } state_type;

endpackage

// ===== src/decay_weighted_period_aggregator.sv =====
`timescale 1ns / 1ps
// Command-driven aggregator: one item at a time, taken when start is high and busy is low.
// Every item gives exactly one result, shown for one cycle under rsp_strobe; the receiver
// cannot stall it. Clear, unused kinds and a zero timeframe answer straight from idle; read
// answers from the lane-sum read. Count and accumulate run the timeframe decode as four
// passes through one shared 17x16 multiplier and then one tally or lane-sum read-modify-
// write; an age out of range ends them before that write. Build visits every age from 0
// to the oldest age counted and takes decay steps of the weight scale as the counts build
// up. After reset and after each clear the block stays busy while it zeroes the tally
// memory one entry a cycle; configuration writes are taken at any time.
module decay_weighted_period_aggregator #(
   parameter int MAX_PERIODS = dwpa_pkg::MAX_PERIODS_DEF,
   parameter int LANES       = dwpa_pkg::LANES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dwpa_pkg::KIND_W-1:0]    req_kind,
   input  logic [dwpa_pkg::TF_W-1:0]      req_timeframe,
   input  logic [dwpa_pkg::LANE_W-1:0]    req_lane,
   input  logic [dwpa_pkg::VALUE_W-1:0]   req_sample_value,
   output logic                           rsp_strobe,
   output logic [dwpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dwpa_pkg::SUM_W-1:0]     rsp_lane_sum,
   output logic [dwpa_pkg::TF_W-1:0]      rsp_newest_timeframe,
   input  logic                           csr_we,
   input  logic [dwpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dwpa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dwpa_pkg::*;

   localparam int AW = $clog2(MAX_PERIODS);
   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

   logic [TALLY_W-1:0] tally_mem  [MAX_PERIODS];
   logic [SCALE_W-1:0] weight_mem [MAX_PERIODS];
   logic [SUM_W-1:0]   lane_mem   [LANES];

   state_type            state_ff, state_in;
   logic [AW-1:0]        sweep_ff, sweep_in;
   logic [AW-1:0]        oldest_ff, oldest_in;
   logic [TF_W-1:0]      newest_ff, newest_in;
   logic [LANES-1:0]     lane_vld_ff, lane_vld_in;
   logic [YEAR_W-1:0]    now_year_ff, now_year_in;
   logic [MONTH_W-1:0]   now_month_ff, now_month_in;
   logic [TENTH_W-1:0]   now_tenth_ff, now_tenth_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [TF_W-1:0]      tf_ff, tf_in;
   logic [LANE_W-1:0]    lane_ff, lane_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [MUL_W-1:0]     mul_ff, mul_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [R_W-1:0]       r_ff, r_in;
   logic [M_W-1:0]       m10_ff, m10_in;
   logic [AW-1:0]        age_ff, age_in;
   logic [AW-1:0]        walk_ff, walk_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SUM_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [TF_W-1:0]      rsp_newest_ff, rsp_newest_in;

   logic [TALLY_W-1:0]   tally_rd_ff;
   logic [SCALE_W-1:0]   weight_rd_ff;
   logic [SUM_W-1:0]     lane_rd_ff;
   logic                 lane_rdv_ff;

   logic                 accept;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [Q_W-1:0]       q_est;
   logic [TF_W-1:0]      r_raw;
   logic                 r_big;
   logic [R_W-1:0]       r_fix;
   logic [D_W-1:0]       digit;
   logic [CODE_W-1:0]    now_code;
   logic [CODE_W-1:0]    tf_code;
   logic [CODE_W-1:0]    age_diff;
   logic                 age_neg;
   logic                 age_old;
   logic [AW-1:0]        age_idx;
   logic                 lane_ok;
   logic [LW-1:0]        lane_raddr;
   logic [SCALE_W-1:0]   scale_next;
   logic                 step_go;
   logic [SUM_W:0]       sum_ext;
   logic [SUM_W-1:0]     sum_sat;
   logic [SUM_W-1:0]     lane_base;

   logic                 tally_we, tally_re;
   logic [AW-1:0]        tally_waddr, tally_raddr;
   logic [TALLY_W-1:0]   tally_wdata;
   logic                 weight_we, weight_re;
   logic                 lane_we;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_lane_sum         = rsp_sum_ff;
   assign rsp_newest_timeframe = rsp_newest_ff;

   assign lane_ok    = (int'(lane_ff) < LANES);
   assign lane_raddr = (state_ff == ST_IDLE) ? LW'(req_lane) : LW'(lane_ff);

   assign q_est = mul_ff[DIV1000_SHIFT +: Q_W];
   assign r_raw = tf_ff - mul_ff[TF_W-1:0];
   assign r_big = (r_raw >= TF_W'(TF_YEAR_DIV));
   assign r_fix = r_big ? R_W'(r_raw - TF_W'(TF_YEAR_DIV)) : R_W'(r_raw);
   assign digit = D_W'(r_ff - mul_ff[R_W-1:0]);

   assign now_code = CODE_W'(now_year_ff) * CODE_W'(PERIODS_PER_YEAR)
                   + CODE_W'(now_month_ff) * CODE_W'(PERIODS_PER_MONTH)
                   + CODE_W'(now_tenth_ff) + CODE_W'(PERIODS_PER_MONTH);
   assign tf_code  = CODE_W'(q_ff) * CODE_W'(PERIODS_PER_YEAR)
                   + CODE_W'(m10_ff) * CODE_W'(PERIODS_PER_MONTH)
                   + CODE_W'(digit);
   assign age_diff = now_code - tf_code;
   assign age_neg  = age_diff[CODE_W-1];
   assign age_old  = !age_neg && (age_diff >= CODE_W'(MAX_PERIODS));
   assign age_idx  = AW'(age_diff);

   assign scale_next = SCALE_W'({1'b0, scale_ff[SCALE_W-1:1]})
                     + SCALE_W'({2'b0, scale_ff[SCALE_W-1:2]}) + SCALE_W'(1);
   assign step_go    = (scale_ff > SCALE_W'(1)) && (count_ff >= COUNT_W'(COUNT_STEP));

   assign lane_base = lane_rdv_ff ? lane_rd_ff : '0;
   assign sum_ext   = {1'b0, lane_base} + (SUM_W + 1)'(mul_ff);
   assign sum_sat   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

   always_comb begin
      unique case (state_ff)
         ST_DIV1: begin
            mul_a = tf_ff;
            mul_b = MUL_B_W'(DIV1000_RECIP);
         end
         ST_DIV2: begin
            mul_a = MUL_A_W'(q_est);
            mul_b = MUL_B_W'(TF_YEAR_DIV);
         end
         ST_DIV3: begin
            mul_a = MUL_A_W'(r_fix);
            mul_b = MUL_B_W'(DIV10_RECIP);
         end
         ST_DIV4: begin
            mul_a = MUL_A_W'(mul_ff[DIV10_SHIFT +: M_W]);
            mul_b = MUL_B_W'(TF_MONTH_DIV);
         end
         ST_ACC_MUL: begin
            mul_a = MUL_A_W'(weight_rd_ff);
            mul_b = value_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = MUL_W'(mul_a) * MUL_W'(mul_b);
   end

   always_comb begin
      logic walk_adv;
      walk_adv      = 1'b0;
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      lane_vld_in   = lane_vld_ff;
      now_year_in   = now_year_ff;
      now_month_in  = now_month_ff;
      now_tenth_in  = now_tenth_ff;
      kind_in       = kind_ff;
      tf_in         = tf_ff;
      lane_in       = lane_ff;
      value_in      = value_ff;
      q_in          = q_ff;
      r_in          = r_ff;
      m10_in        = m10_ff;
      age_in        = age_ff;
      walk_in       = walk_ff;
      scale_in      = scale_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_sum_in    = '0;
      tally_we      = 1'b0;
      tally_re      = 1'b0;
      tally_waddr   = age_ff;
      tally_raddr   = age_idx;
      tally_wdata   = '0;
      weight_we     = 1'b0;
      weight_re     = 1'b0;
      lane_we       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NOW_YEAR:  now_year_in  = csr_wdata[YEAR_W-1:0];
            CSR_NOW_MONTH: now_month_in = csr_wdata[MONTH_W-1:0];
            CSR_NOW_TENTH: now_tenth_in = csr_wdata[TENTH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_SWEEP: begin
            tally_we    = 1'b1;
            tally_waddr = sweep_ff;
            if (sweep_ff == AW'(MAX_PERIODS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               tf_in    = req_timeframe;
               lane_in  = req_lane;
               value_in = req_sample_value;
               unique case (req_kind)
                  KIND_CLEAR: begin
                     oldest_in    = '0;
                     newest_in    = '0;
                     lane_vld_in  = '0;
                     sweep_in     = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  KIND_COUNT, KIND_ACCUM: begin
                     if (req_timeframe == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_TF_ZERO;
                     end else begin
                        state_in = ST_DIV1;
                     end
                  end
                  KIND_BUILD: begin
                     walk_in  = '0;
                     scale_in = SCALE_W'(SCALE_INIT);
                     count_in = '0;
                     state_in = ST_BLD_RD;
                  end
                  KIND_READ: begin
                     state_in = ST_RDOUT;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIV1: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            q_in     = q_est;
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            q_in     = q_ff + Q_W'(r_big);
            r_in     = r_fix;
            state_in = ST_DIV4;
         end
         ST_DIV4: begin
            m10_in   = mul_ff[DIV10_SHIFT +: M_W];
            state_in = ST_AGE;
         end
         ST_AGE: begin
            if (age_neg) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_AGE_NEG;
               state_in      = ST_IDLE;
            end else if (age_old) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_AGE_OLD;
               state_in      = ST_IDLE;
            end else begin
               age_in    = age_idx;
               tally_re  = 1'b1;
               weight_re = 1'b1;
               state_in  = (kind_ff == KIND_COUNT) ? ST_CNT : ST_ACC_MUL;
            end
         end
         ST_CNT: begin
            tally_we    = 1'b1;
            tally_waddr = age_ff;
            tally_wdata = (tally_rd_ff == TALLY_W'(TALLY_MAX)) ? tally_rd_ff
                                                               : tally_rd_ff + TALLY_W'(1);
            if (age_ff > oldest_ff) begin
               oldest_in = age_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_ACC_MUL: begin
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            if (tf_ff > newest_ff) begin
               newest_in = tf_ff;
            end
            if (lane_ok) begin
               lane_we                   = 1'b1;
               lane_vld_in[LW'(lane_ff)] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RDOUT: begin
            rsp_sum_in   = (lane_ok && lane_rdv_ff) ? lane_rd_ff : '0;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_BLD_RD: begin
            tally_re    = 1'b1;
            tally_raddr = walk_ff;
            state_in    = ST_BLD_ADD;
         end
         ST_BLD_ADD: begin
            weight_we = 1'b1;
            count_in  = count_ff + COUNT_W'(tally_rd_ff) + COUNT_W'(COUNT_BIAS);
            state_in  = ST_BLD_STEP;
         end
         ST_BLD_STEP: begin
            if (step_go) begin
               if (scale_next == scale_ff) begin
                  count_in = COUNT_W'(count_ff[STEP_BITS-1:0]);
                  walk_adv = 1'b1;
               end else begin
                  scale_in = scale_next;
                  count_in = count_ff - COUNT_W'(COUNT_STEP);
               end
            end else begin
               walk_adv = 1'b1;
            end
            if (walk_adv) begin
               if (walk_ff == oldest_ff) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  walk_in  = walk_ff + AW'(1);
                  state_in = ST_BLD_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_newest_in = newest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         lane_vld_ff  <= '0;
         now_year_ff  <= '0;
         now_month_ff <= '0;
         now_tenth_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         lane_vld_ff  <= lane_vld_in;
         now_year_ff  <= now_year_in;
         now_month_ff <= now_month_in;
         now_tenth_ff <= now_tenth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      tf_ff         <= tf_in;
      lane_ff       <= lane_in;
      value_ff      <= value_in;
      mul_ff        <= mul_in;
      q_ff          <= q_in;
      r_ff          <= r_in;
      m10_ff        <= m10_in;
      age_ff        <= age_in;
      walk_ff       <= walk_in;
      scale_ff      <= scale_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_newest_ff <= rsp_newest_in;
   end

   always_ff @(posedge clock) begin
      if (tally_we) begin
         tally_mem[tally_waddr] <= tally_wdata;
      end
      if (tally_re) begin
         tally_rd_ff <= tally_mem[tally_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (weight_we) begin
         weight_mem[walk_ff] <= scale_ff;
      end
      if (weight_re) begin
         weight_rd_ff <= weight_mem[age_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (lane_we) begin
         lane_mem[LW'(lane_ff)] <= sum_sat;
      end
      lane_rd_ff  <= lane_mem[lane_raddr];
      lane_rdv_ff <= lane_vld_ff[lane_raddr];
   end

endmodule

// ===== dv/decay_weighted_period_aggregator_tb.sv =====
`timescale 1ns / 1ps
module decay_weighted_period_aggregator_tb;
   import dwpa_pkg::*;

   localparam int TF_MAX = 99999;
   localparam int VALUE_MAX = (1 << VALUE_W) - 1;
   localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [TF_W-1:0]    tf;
      logic [LANE_W-1:0]  lane;
      logic [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct {
      status_type      status;
      logic [SUM_W-1:0] sum;
      logic [TF_W-1:0]  newest;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind = '0;
   logic [TF_W-1:0]       req_timeframe = '0;
   logic [LANE_W-1:0]     req_lane = '0;
   logic [VALUE_W-1:0]    req_sample_value = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SUM_W-1:0]      rsp_lane_sum;
   logic [TF_W-1:0]       rsp_newest_timeframe;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cmd_type   cmd_q[$];
   reply_type reply_q[$];
   cmd_type   cur_cmd;
   reply_type exp_reply;
   logic   req_taken = 1'b0;
   int     gap_left = 0;
   bit     calm = 1'b0;
   int     mismatches = 0;

   // aggregator state as predicted
   int                 now_year = 0, now_month = 0, now_tenth = 0;
   logic [TALLY_W-1:0] tally [MAX_PERIODS_DEF];
   logic [SCALE_W-1:0] weight [MAX_PERIODS_DEF];
   longint unsigned    sums [LANES_DEF];
   int                 oldest = 0;
   int                 newest = 0;

   // stimulus planning: ages with a built weight are 0..built_top
   int gen_oldest = 0;
   int built_top = -1;

   decay_weighted_period_aggregator u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_kind             (req_kind),
      .req_timeframe        (req_timeframe),
      .req_lane             (req_lane),
      .req_sample_value     (req_sample_value),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_lane_sum         (rsp_lane_sum),
      .rsp_newest_timeframe (rsp_newest_timeframe),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < MAX_PERIODS_DEF; i++) tally[i] = '0;
      for (int i = 0; i < LANES_DEF; i++) sums[i] = 0;
   end

   function automatic int now_total();
      return now_year * PERIODS_PER_YEAR + now_month * PERIODS_PER_MONTH + now_tenth;
   endfunction

   function automatic status_type decode_age(input int tf, output int age);
      int a;
      age = 0;
      if (tf == 0) return STATUS_TF_ZERO;
      a = (now_year - tf / TF_YEAR_DIV) * PERIODS_PER_YEAR
        + (now_month - ((tf % TF_YEAR_DIV) / TF_MONTH_DIV - 1)) * PERIODS_PER_MONTH
        + (now_tenth - tf % TF_MONTH_DIV);
      if (a < 0) return STATUS_AGE_NEG;
      if (a >= MAX_PERIODS_DEF) return STATUS_AGE_OLD;
      age = a;
      return STATUS_OK;
   endfunction

   function automatic int tf_for_age(int a);
      int rest;
      rest = now_total() - a;
      return (rest / PERIODS_PER_YEAR) * TF_YEAR_DIV
           + ((rest % PERIODS_PER_YEAR) / PERIODS_PER_MONTH + 1) * TF_MONTH_DIV
           + rest % PERIODS_PER_MONTH;
   endfunction

   function automatic reply_type apply_cmd(cmd_type c);
      reply_type       r;
      int              a, scale, cnt, nxt;
      longint unsigned add;
      r.status = STATUS_OK;
      r.sum = '0;
      case (c.kind)
         KIND_CLEAR: begin
            for (int i = 0; i < MAX_PERIODS_DEF; i++) tally[i] = '0;
            for (int i = 0; i < LANES_DEF; i++) sums[i] = 0;
            oldest = 0;
            newest = 0;
         end
         KIND_COUNT: begin
            r.status = decode_age(c.tf, a);
            if (r.status == STATUS_OK) begin
               if (a > oldest) oldest = a;
               if (tally[a] != TALLY_W'(TALLY_MAX)) tally[a] = tally[a] + 1'b1;
            end
         end
         KIND_BUILD: begin
            scale = SCALE_INIT;
            cnt = 0;
            for (int i = 0; i <= oldest; i++) begin
               weight[i] = SCALE_W'(scale);
               cnt += int'(tally[i]) + COUNT_BIAS;
               while (scale > 1 && cnt >= COUNT_STEP) begin
                  nxt = (scale >> 1) + (scale >> 2) + 1;
                  if (nxt == scale) begin
                     cnt = cnt % COUNT_STEP;
                     break;
                  end
                  scale = nxt;
                  cnt -= COUNT_STEP;
               end
            end
         end
         KIND_ACCUM: begin
            r.status = decode_age(c.tf, a);
            if (r.status == STATUS_OK) begin
               if (int'(c.tf) > newest) newest = c.tf;
               if (c.lane < LANES_DEF) begin
                  add = longint'(weight[a]) * longint'(c.value);
                  if (add > SUM_CAP - sums[c.lane]) sums[c.lane] = SUM_CAP;
                  else sums[c.lane] = sums[c.lane] + add;
               end
            end
         end
         KIND_READ: begin
            if (c.lane < LANES_DEF) r.sum = sums[c.lane][SUM_W-1:0];
         end
         default: ;
      endcase
      r.newest = TF_W'(newest);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      if (mismatches < 100)
         $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic push_item(logic [KIND_W-1:0] kind, int tf, int lane, int value);
      cmd_type    c;
      status_type st;
      int         a;
      st = decode_age(tf, a);
      // never accumulate into an age without a built weight
      if (kind == KIND_ACCUM && st == STATUS_OK && a > built_top) kind = KIND_COUNT;
      if (kind == KIND_COUNT && st == STATUS_OK && a > gen_oldest) gen_oldest = a;
      if (kind == KIND_BUILD && gen_oldest > built_top) built_top = gen_oldest;
      if (kind == KIND_CLEAR) gen_oldest = 0;
      c.kind = kind;
      c.tf = TF_W'(tf);
      c.lane = LANE_W'(lane);
      c.value = VALUE_W'(value);
      cmd_q.push_back(c);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (cmd_q.size() != 0 || start || reply_q.size() != 0);
      @(negedge clock);
   endtask

   task automatic write_cfg(int y, int m, int t);
      drain();
      now_year = y;
      now_month = m;
      now_tenth = t;
      csr_we <= 1'b1;
      csr_index <= CSR_NOW_YEAR;
      csr_wdata <= CSR_DATA_W'(y);
      @(negedge clock);
      csr_index <= CSR_NOW_MONTH;
      csr_wdata <= CSR_DATA_W'(m);
      @(negedge clock);
      csr_index <= CSR_NOW_TENTH;
      csr_wdata <= CSR_DATA_W'(t);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int pick_age(int top);
      if ($urandom_range(3) != 0) return $urandom_range(top < 15 ? top : 15);
      return $urandom_range(top);
   endfunction

   function automatic int pick_value();
      int p;
      p = $urandom_range(9);
      if (p == 0) return 0;
      if (p == 1) return VALUE_MAX;
      return $urandom_range(VALUE_MAX);
   endfunction

   function automatic int noise_tf();
      return ($urandom_range(3) == 0) ? 0 : $urandom_range(TF_MAX);
   endfunction

   task automatic run_random(int n);
      int pick, top, acc_top;
      repeat (n) begin
         pick = $urandom_range(99);
         top = now_total() < MAX_PERIODS_DEF - 1 ? now_total() : MAX_PERIODS_DEF - 1;
         acc_top = top < built_top ? top : built_top;
         if (pick < 5)
            push_item(KIND_CLEAR, $urandom_range(TF_MAX), $urandom_range(LANES_DEF - 1),
                      $urandom_range(VALUE_MAX));
         else if (pick < 35)
            push_item(KIND_COUNT,
                      ($urandom_range(9) < 8) ? tf_for_age(pick_age(top)) : noise_tf(),
                      $urandom_range(LANES_DEF - 1), $urandom_range(VALUE_MAX));
         else if (pick < 43)
            push_item(KIND_BUILD, $urandom_range(TF_MAX), $urandom_range(LANES_DEF - 1),
                      $urandom_range(VALUE_MAX));
         else if (pick < 78)
            push_item(KIND_ACCUM,
                      (acc_top >= 0 && $urandom_range(9) != 0) ?
                         tf_for_age(pick_age(acc_top)) : noise_tf(),
                      $urandom_range(LANES_DEF - 1), pick_value());
         else if (pick < 96)
            push_item(KIND_READ, $urandom_range(TF_MAX), $urandom_range(LANES_DEF - 1),
                      $urandom_range(VALUE_MAX));
         else
            push_item(KIND_W'($urandom_range(2 ** KIND_W - 1, KIND_READ + 1)),
                      $urandom_range(TF_MAX), $urandom_range(LANES_DEF - 1),
                      $urandom_range(VALUE_MAX));
      end
   endtask

   // driver: hold an item until transfer, then gap or advance
   always @(negedge clock) begin
      if (!start || req_taken) begin
         if (gap_left == 0 && cmd_q.size() != 0) begin
            cur_cmd = cmd_q.pop_front();
            start <= 1'b1;
            req_kind <= cur_cmd.kind;
            req_timeframe <= cur_cmd.tf;
            req_lane <= cur_cmd.lane;
            req_sample_value <= cur_cmd.value;
            gap_left <= (!calm && $urandom_range(99) < 32) ? $urandom_range(12, 1) : 0;
         end else begin
            start <= 1'b0;
            req_kind <= KIND_W'($urandom);
            req_timeframe <= TF_W'($urandom);
            req_lane <= LANE_W'($urandom);
            req_sample_value <= VALUE_W'($urandom);
            if (gap_left != 0) gap_left <= gap_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= start && !busy && !reset;
      if (start && !busy && !reset) reply_q.push_back(apply_cmd(cur_cmd));
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (reply_q.size() == 0) begin
            report_mismatch("result with nothing pending, status", rsp_status, 0);
         end else begin
            exp_reply = reply_q.pop_front();
            if (rsp_status !== exp_reply.status)
               report_mismatch("status", rsp_status, exp_reply.status);
            if (rsp_lane_sum !== exp_reply.sum)
               report_mismatch("lane_sum", rsp_lane_sum, exp_reply.sum);
            if (rsp_newest_timeframe !== exp_reply.newest)
               report_mismatch("newest_timeframe", rsp_newest_timeframe, exp_reply.newest);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("FAIL decay_weighted_period_aggregator");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      write_cfg(99, 11, 2);
      push_item(KIND_READ, 0, 0, 0);
      push_item(KIND_COUNT, 0, 0, 0);
      push_item(KIND_ACCUM, 0, 3, 1);
      push_item(KIND_COUNT, TF_MAX, 0, 0);
      push_item(KIND_COUNT, tf_for_age(MAX_PERIODS_DEF - 1), 0, 0);
      push_item(KIND_COUNT, tf_for_age(MAX_PERIODS_DEF), 0, 0);
      push_item(KIND_COUNT, tf_for_age(0), 0, 0);
      push_item(KIND_COUNT, tf_for_age(0), 0, 0);
      push_item(KIND_COUNT, tf_for_age(1), 0, 0);
      for (int k = KIND_READ + 1; k < 2 ** KIND_W; k++)
         push_item(KIND_W'(k), TF_MAX, LANES_DEF - 1, VALUE_MAX);
      push_item(KIND_BUILD, 0, 0, 0);
      push_item(KIND_ACCUM, tf_for_age(0), 0, VALUE_MAX);
      push_item(KIND_ACCUM, tf_for_age(MAX_PERIODS_DEF - 1), LANES_DEF - 1, VALUE_MAX);
      push_item(KIND_ACCUM, tf_for_age(1), 17, 0);
      push_item(KIND_ACCUM, tf_for_age(MAX_PERIODS_DEF), 2, 7);
      push_item(KIND_READ, 0, 0, 0);
      push_item(KIND_READ, 0, LANES_DEF - 1, 0);
      push_item(KIND_READ, 0, 17, 0);
      push_item(KIND_CLEAR, 0, 0, 0);
      push_item(KIND_READ, 0, LANES_DEF - 1, 0);
      push_item(KIND_ACCUM, tf_for_age(0), 5, 1);
      push_item(KIND_READ, 0, 5, 0);

      // pile up one tally entry, then build and use the weights past it
      write_cfg(28, 5, 1);
      calm = 1'b1;
      push_item(KIND_CLEAR, 0, 0, 0);
      repeat (48) push_item(KIND_COUNT, tf_for_age(3), 0, 0);
      push_item(KIND_COUNT, tf_for_age(12), 0, 0);
      push_item(KIND_BUILD, 0, 0, 0);
      for (int a = 0; a <= 12; a++) push_item(KIND_ACCUM, tf_for_age(a), a, pick_value());
      for (int a = 0; a <= 12; a++) push_item(KIND_READ, 0, a, 0);
      drain();
      calm = 1'b0;

      write_cfg(0, 0, 0);
      run_random(120);
      write_cfg(57, 7, 0);
      run_random(120);
      write_cfg(99, 11, 2);
      run_random(120);
      repeat (2) begin
         write_cfg($urandom_range(99), $urandom_range(11), $urandom_range(2));
         run_random(120);
      end
      drain();
      repeat (800) @(negedge clock);
      if (mismatches == 0)
         $display("PASS decay_weighted_period_aggregator");
      else
         $display("FAIL decay_weighted_period_aggregator");
      $finish;
   end

endmodule
